[rtl/dpsq_pkg.sv]
// ----------------------------------------------------------------------------
// dpsq_pkg
// Shared widths, sizes and codes of the deduplicating service queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dpsq_pkg;

  // Queue and service number space
  localparam int QUEUE_DEPTH   = 16;
  localparam int SERVICE_COUNT = 64;

  // Fixed field widths
  localparam int CMD_W    = 2;
  localparam int SVC_W    = 6;
  localparam int STATUS_W = 3;
  localparam int QCOUNT_W = 5;
  localparam int MASK_W   = 64;

  // Occupancy counter holds zero up to the full depth
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef logic [SVC_W-1:0]  svc_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [MASK_W-1:0] mask_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_REQUEST = 2'd0,
    CMD_TAKE    = 2'd1,
    CMD_FINISH  = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED        = 3'd0,
    ST_NOT_REGISTERED  = 3'd1,
    ST_ALREADY_PENDING = 3'd2,
    ST_FULL            = 3'd3,
    ST_TAKEN           = 3'd4,
    ST_EMPTY           = 3'd5,
    ST_FINISHED        = 3'd6
  } status_t;

  // Per-cycle control handed to every cell of the row
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/dpsq_if.sv]
// ----------------------------------------------------------------------------
// dpsq interfaces
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface dpsq_req_if;
  logic                        valid;
  logic                        ready;
  logic [dpsq_pkg::CMD_W-1:0]  command;
  logic [dpsq_pkg::SVC_W-1:0]  service_number;

  modport source (output valid, output command, output service_number, input ready);
  modport sink   (input valid, input command, input service_number, output ready);
endinterface

interface dpsq_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [dpsq_pkg::STATUS_W-1:0]  status;
  logic [dpsq_pkg::SVC_W-1:0]     service_out;
  logic                           deferred_request;
  logic [dpsq_pkg::QCOUNT_W-1:0]  queued_count;

  modport source (output valid, output status, output service_out,
                  output deferred_request, output queued_count, input ready);
  modport sink   (input valid, input status, input service_out,
                  input deferred_request, input queued_count, output ready);
endinterface

`default_nettype wire

[rtl/dedup_pending_service_queue.sv]
// ----------------------------------------------------------------------------
// dedup_pending_service_queue
// Queue of pending service numbers that holds each number at most once.
// ----------------------------------------------------------------------------
// Takes one item per clock while ready and returns exactly one result item
// for it, in the cycle after acceptance, from an output register; the request
// side stays ready while that register is empty or being emptied in the same
// cycle. The queue is a row of QUEUE_DEPTH cells with the oldest entry in the
// first cell: a request loads the cell at the current occupancy, a take
// shifts the whole row one place towards the head. Numbers zero and
// SERVICE_COUNT-1 are never registered. A taken number stays pending until a
// finish item clears it. The registration mask is written through
// cfg_wr_en / cfg_wr_data by the user, only while idle; not enforced here.
// ----------------------------------------------------------------------------
`default_nettype none

module dedup_pending_service_queue (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic [dpsq_pkg::MASK_W-1:0] cfg_wr_data,
  dpsq_req_if.sink                         req,
  dpsq_rsp_if.source                       rsp
);

  // State
  dpsq_pkg::mask_t registered_mask;
  dpsq_pkg::mask_t pending_marks;
  dpsq_pkg::mask_t pending_marks_next;
  dpsq_pkg::cnt_t  entry_count;
  dpsq_pkg::cnt_t  entry_count_next;
  logic            deferred_flag;
  logic            deferred_flag_next;

  // Output register
  logic                            rsp_valid;
  dpsq_pkg::status_t               status_q;
  dpsq_pkg::status_t               status_next;
  dpsq_pkg::svc_t                  service_out_q;
  dpsq_pkg::svc_t                  taken_next;

  logic            accept;
  logic            push;
  logic            pop;
  logic            registered;
  dpsq_pkg::svc_t  num;
  dpsq_pkg::svc_t  head_data;

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign num       = req.service_number;

  // Registration check, with the two reserved numbers excluded
  assign registered = (num != '0)
                   && (int'(num) < dpsq_pkg::SERVICE_COUNT)
                   && (int'(num) != dpsq_pkg::SERVICE_COUNT - 1)
                   && registered_mask[num];

  // Decode one command against the current state
  always_comb begin
    status_next        = dpsq_pkg::ST_NOT_REGISTERED;
    taken_next         = '0;
    push               = 1'b0;
    pop                = 1'b0;
    pending_marks_next = pending_marks;
    entry_count_next   = entry_count;
    deferred_flag_next = deferred_flag;
    unique case (dpsq_pkg::cmd_t'(req.command))
      dpsq_pkg::CMD_REQUEST: begin
        if (!registered) begin
          status_next = dpsq_pkg::ST_NOT_REGISTERED;
        end else if (pending_marks[num]) begin
          status_next = dpsq_pkg::ST_ALREADY_PENDING;
        end else if (int'(entry_count) >= dpsq_pkg::QUEUE_DEPTH) begin
          status_next = dpsq_pkg::ST_FULL;
        end else begin
          status_next             = dpsq_pkg::ST_ACCEPTED;
          push                    = 1'b1;
          pending_marks_next[num] = 1'b1;
          entry_count_next        = entry_count + dpsq_pkg::CNT_W'(1);
          deferred_flag_next      = 1'b1;
        end
      end
      dpsq_pkg::CMD_TAKE: begin
        if (entry_count == '0) begin
          status_next        = dpsq_pkg::ST_EMPTY;
          deferred_flag_next = 1'b0;
        end else begin
          status_next      = dpsq_pkg::ST_TAKEN;
          taken_next       = head_data;
          pop              = 1'b1;
          entry_count_next = entry_count - dpsq_pkg::CNT_W'(1);
        end
      end
      dpsq_pkg::CMD_FINISH: begin
        status_next = dpsq_pkg::ST_FINISHED;
        if (int'(num) < dpsq_pkg::SERVICE_COUNT) begin
          pending_marks_next[num] = 1'b0;
        end
      end
      default: begin
        status_next = dpsq_pkg::ST_NOT_REGISTERED;
      end
    endcase
  end

  // Cell row holding the queue entries
  dpsq_top_cells u_cells (
    .clk       (clk),
    .push      (accept && push),
    .pop       (accept && pop),
    .count     (entry_count),
    .push_data (num),
    .head_data (head_data)
  );

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      registered_mask <= '0;
      pending_marks   <= '0;
      entry_count     <= '0;
      deferred_flag   <= 1'b0;
      rsp_valid       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        registered_mask <= cfg_wr_data;
      end
      if (accept) begin
        pending_marks <= pending_marks_next;
        entry_count   <= entry_count_next;
        deferred_flag <= deferred_flag_next;
        rsp_valid     <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Result payload, loaded on acceptance
  always_ff @(posedge clk) begin
    if (accept) begin
      status_q      <= status_next;
      service_out_q <= taken_next;
    end
  end

  assign rsp.valid            = rsp_valid;
  assign rsp.status           = status_q;
  assign rsp.service_out      = service_out_q;
  assign rsp.deferred_request = deferred_flag;
  assign rsp.queued_count     = dpsq_pkg::QCOUNT_W'(entry_count);

endmodule

`default_nettype wire

[rtl/dpsq_cell.sv]
// ----------------------------------------------------------------------------
// dpsq_cell
// One queue slot: shifts towards the head on a take, loads on a request.
// ----------------------------------------------------------------------------
`default_nettype none

module dpsq_cell (
  input  wire logic                 clk,
  input  wire dpsq_pkg::cell_ctrl_t ctrl,
  input  wire dpsq_pkg::svc_t       load_data,
  input  wire dpsq_pkg::svc_t       neighbour_data,
  output dpsq_pkg::svc_t            data
);

  dpsq_pkg::svc_t data_next;

  // Take wins over load; the two never coincide
  always_comb begin
    data_next = data;
    if (ctrl.shift) begin
      data_next = neighbour_data;
    end else if (ctrl.load) begin
      data_next = load_data;
    end
  end

  // Payload only, no reset
  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

`default_nettype wire

[rtl/dpsq_top_cells.sv]
// ----------------------------------------------------------------------------
// dpsq_top_cells
// Row of queue cells; the head sits in cell zero.
// ----------------------------------------------------------------------------
`default_nettype none

module dpsq_top_cells (
  input  wire logic           clk,
  input  wire logic           push,
  input  wire logic           pop,
  input  wire dpsq_pkg::cnt_t count,
  input  wire dpsq_pkg::svc_t push_data,
  output dpsq_pkg::svc_t      head_data
);

  dpsq_pkg::svc_t     cell_data [dpsq_pkg::QUEUE_DEPTH];
  dpsq_pkg::cell_ctrl_t cell_ctrl [dpsq_pkg::QUEUE_DEPTH];

  genvar i;
  generate
    for (i = 0; i < dpsq_pkg::QUEUE_DEPTH; i++) begin : g_cell
      dpsq_pkg::svc_t nb_data;

      // Load the first free slot, shift the whole row on a take
      assign cell_ctrl[i].shift = pop;
      assign cell_ctrl[i].load  = push && (count == dpsq_pkg::CNT_W'(i));

      if (i == dpsq_pkg::QUEUE_DEPTH - 1) begin : g_last
        assign nb_data = cell_data[i];
      end else begin : g_mid
        assign nb_data = cell_data[i+1];
      end

      dpsq_cell u_cell (
        .clk            (clk),
        .ctrl           (cell_ctrl[i]),
        .load_data      (push_data),
        .neighbour_data (nb_data),
        .data           (cell_data[i])
      );
    end
  endgenerate

  assign head_data = cell_data[0];

endmodule

`default_nettype wire

[dv/dedup_pending_service_queue_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dedup_pending_service_queue_test
// Self-checking bench for the deduplicating pending service queue.
// ----------------------------------------------------------------------------
// Drives request, take and finish items through the request channel. A
// bit-accurate behavioural copy of the queue predicts each result item, and
// every result is compared field by field against the oldest prediction.
// Directed checks cover reset, the never-registered numbers, pending
// handling and a full queue. Random phases then run under several
// registration masks. The sender works in bursts with gaps, and the receiver
// stalls on its own pattern, including one long hold-off.
// ----------------------------------------------------------------------------

module dedup_pending_service_queue_test;
  import dpsq_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam mask_t NEVER_REGISTERED = (mask_t'(1) << (SERVICE_COUNT - 1)) | mask_t'(1);
  localparam longint RUN_LIMIT_NS = 5_000_000;
  localparam int LONG_HOLD_CYCLES = 300;

  typedef struct packed {
    status_t             status;
    svc_t                service_out;
    logic                deferred;
    logic [QCOUNT_W-1:0] count;
  } outcome_t;

  typedef enum int {ALWAYS_READY, COIN_FLIP, MOSTLY_READY} stall_mode_t;

  logic  clk;
  logic  rst;
  logic  cfg_wr_en;
  mask_t cfg_wr_data;

  dpsq_req_if req_ch ();
  dpsq_rsp_if rsp_ch ();

  dedup_pending_service_queue i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req_ch),
    .rsp         (rsp_ch)
  );

  // Behavioural copy of the queue state
  svc_t  queued_numbers[$];
  mask_t pending_numbers;
  mask_t registered_numbers;
  logic  deferral_raised;

  outcome_t awaited_outcomes[$];
  int       errors;
  int       burst_left;
  int       hold_request;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

  // Work out the result of one command and advance the copied state
  function automatic outcome_t apply_service_command(logic [CMD_W-1:0] cmd, svc_t num);
    outcome_t res;
    logic     known;
    res.status      = ST_NOT_REGISTERED;
    res.service_out = '0;
    known = registered_numbers[num] && num != 0 && num != SERVICE_COUNT - 1
            && num < SERVICE_COUNT;
    case (cmd)
      CMD_REQUEST: begin
        if (!known) begin
          res.status = ST_NOT_REGISTERED;
        end else if (pending_numbers[num]) begin
          res.status = ST_ALREADY_PENDING;
        end else if (queued_numbers.size() >= QUEUE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          pending_numbers[num] = 1'b1;
          queued_numbers.push_back(num);
          deferral_raised = 1'b1;
          res.status = ST_ACCEPTED;
        end
      end
      CMD_TAKE: begin
        if (queued_numbers.size() == 0) begin
          deferral_raised = 1'b0;
          res.status = ST_EMPTY;
        end else begin
          res.service_out = queued_numbers.pop_front();
          res.status = ST_TAKEN;
        end
      end
      CMD_FINISH: begin
        if (num < SERVICE_COUNT) pending_numbers[num] = 1'b0;
        res.status = ST_FINISHED;
      end
      default: ;
    endcase
    res.deferred = deferral_raised;
    res.count    = QCOUNT_W'(queued_numbers.size());
    return res;
  endfunction

  // Replace num by a random member of the set; leave it if the set is empty
  function automatic void pick_member(mask_t set, inout svc_t num);
    int remaining;
    if (set == '0) return;
    remaining = $urandom_range(0, $countones(set) - 1);
    for (int i = 0; i < SERVICE_COUNT; i++) begin
      if (set[i]) begin
        if (remaining == 0) begin
          num = svc_t'(i);
          return;
        end
        remaining--;
      end
    end
  endfunction

  // Offer one item in the current burst, or open a new burst after a gap
  task automatic offer_command(logic [CMD_W-1:0] cmd, svc_t num);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        req_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    req_ch.valid          <= 1'b1;
    req_ch.command        <= cmd;
    req_ch.service_number <= num;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    burst_left--;
    awaited_outcomes.push_back(apply_service_command(cmd, num));
  endtask

  // Drop valid and hold until every outstanding result has come back
  task automatic await_idle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    burst_left = 0;
    while (awaited_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic write_mask(mask_t value);
    await_idle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    registered_numbers = value;
  endtask

  // Mostly well-formed items: free registered numbers, finishes of pending ones
  task automatic pick_random_item(int take_weight, output logic [CMD_W-1:0] cmd,
                                  output svc_t num);
    int    roll;
    mask_t open_set;
    roll     = $urandom_range(0, 99);
    num      = svc_t'($urandom_range(0, SERVICE_COUNT - 1));
    open_set = registered_numbers & ~pending_numbers & ~NEVER_REGISTERED;
    if (roll < 4) begin
      cmd = CMD_UNUSED;
    end else if (roll < 4 + take_weight) begin
      cmd = CMD_TAKE;
    end else if ($urandom_range(0, 2) != 2) begin
      cmd = CMD_REQUEST;
      if ($urandom_range(0, 4) != 0)
        pick_member(($urandom_range(0, 3) != 0) ? open_set : registered_numbers, num);
    end else begin
      cmd = CMD_FINISH;
      if ($urandom_range(0, 3) != 0) pick_member(pending_numbers, num);
    end
  endtask

  task automatic report_mismatch(string field, int unsigned expv, int unsigned actv);
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, expv, actv);
    errors++;
  endtask

  // Compare each accepted result item with the oldest prediction
  always @(posedge clk) begin : check_results
    outcome_t exp_res;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (awaited_outcomes.size() == 0) begin
        $display("%0t: unexpected result item: expected none, actual status %0d",
                 $time, rsp_ch.status);
        errors++;
      end else begin
        exp_res = awaited_outcomes.pop_front();
        if (rsp_ch.status !== exp_res.status)
          report_mismatch("status", exp_res.status, rsp_ch.status);
        if (rsp_ch.service_out !== exp_res.service_out)
          report_mismatch("service_out", exp_res.service_out, rsp_ch.service_out);
        if (rsp_ch.deferred_request !== exp_res.deferred)
          report_mismatch("deferred_request", exp_res.deferred, rsp_ch.deferred_request);
        if (rsp_ch.queued_count !== exp_res.count)
          report_mismatch("queued_count", exp_res.count, rsp_ch.queued_count);
      end
    end
  end

  // Receiver: stall on a changing pattern, or hold off for a requested stretch
  initial begin : receiver_pattern
    stall_mode_t mode;
    int          mode_left;
    int          hold_left;
    rsp_ch.ready = 1'b0;
    mode      = ALWAYS_READY;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (mode_left == 0) begin
        mode      = stall_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        case (mode)
          ALWAYS_READY: rsp_ch.ready <= 1'b1;
          COIN_FLIP:    rsp_ch.ready <= 1'($urandom_range(0, 1));
          default:      rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Empty take and unregistered request straight after reset
  task automatic test_after_reset();
    offer_command(CMD_TAKE, svc_t'(0));
    offer_command(CMD_REQUEST, svc_t'(5));
  endtask

  // Never-registered numbers, pending marks that outlive a take, odd command
  task automatic test_registration_edges();
    write_mask('1);
    offer_command(CMD_REQUEST, svc_t'(0));
    offer_command(CMD_REQUEST, svc_t'(SERVICE_COUNT - 1));
    offer_command(CMD_REQUEST, svc_t'(1));
    offer_command(CMD_REQUEST, svc_t'(1));
    offer_command(CMD_TAKE, svc_t'(0));
    offer_command(CMD_TAKE, svc_t'(0));
    offer_command(CMD_REQUEST, svc_t'(1));
    offer_command(CMD_FINISH, svc_t'(40));
    offer_command(CMD_FINISH, svc_t'(1));
    offer_command(CMD_UNUSED, svc_t'(SERVICE_COUNT - 1));
  endtask

  // Fill the queue, then probe the check order while full
  task automatic test_full_ring();
    offer_command(CMD_REQUEST, svc_t'(SERVICE_COUNT - 2));
    offer_command(CMD_REQUEST, svc_t'(1));
    for (int n = 2; n < QUEUE_DEPTH; n++) offer_command(CMD_REQUEST, svc_t'(n));
    offer_command(CMD_REQUEST, svc_t'(20));
    offer_command(CMD_REQUEST, svc_t'(SERVICE_COUNT - 2));
    offer_command(CMD_REQUEST, svc_t'(0));
  endtask

  // Hold the receiver off while items keep coming, so the input stalls
  task automatic test_output_backpressure();
    logic [CMD_W-1:0] cmd;
    svc_t             num;
    await_idle();
    hold_request = LONG_HOLD_CYCLES;
    for (int i = 0; i < 48; i++) begin
      pick_random_item(30, cmd, num);
      offer_command(cmd, num);
    end
    await_idle();
  endtask

  task automatic test_random_phases();
    mask_t            mask;
    int               take_weight;
    int               items;
    logic [CMD_W-1:0] cmd;
    svc_t             num;
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0:       mask = '1;
        4:       mask = '0;
        7:       mask = NEVER_REGISTERED;
        default: mask = (phase % 2) ? {$urandom, $urandom}
                                    : ({$urandom, $urandom} & {$urandom, $urandom});
      endcase
      write_mask(mask);
      take_weight = 15 * $urandom_range(1, 3);
      items = ($countones(mask & ~NEVER_REGISTERED) < 4) ? 40 : 220;
      for (int i = 0; i < items; i++) begin
        pick_random_item(take_weight, cmd, num);
        offer_command(cmd, num);
      end
    end
  endtask

  initial begin
    rst                   = 1'b1;
    cfg_wr_en             = 1'b0;
    cfg_wr_data           = '0;
    req_ch.valid          = 1'b0;
    req_ch.command        = '0;
    req_ch.service_number = '0;
    errors                = 0;
    burst_left            = 0;
    hold_request          = 0;
    pending_numbers       = '0;
    registered_numbers    = '0;
    deferral_raised       = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_after_reset();
    test_registration_edges();
    test_full_ring();
    test_output_backpressure();
    test_random_phases();

    // Drain, then leave time for stray results
    await_idle();
    repeat (4) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

[files.f]
rtl/dpsq_pkg.sv
rtl/dpsq_if.sv
rtl/dpsq_cell.sv
rtl/dpsq_top_cells.sv
rtl/dedup_pending_service_queue.sv
dv/dedup_pending_service_queue_test.sv
